FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bchd_pkg.sv
// Shared types and codes of the click / double-click / hold detector.
// No dependencies.
package bchd_pkg;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT_UP = 2'd1;
  localparam logic [1:0] PH_WAIT_P2 = 2'd2;
  localparam logic [1:0] PH_WAIT_U2 = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CLICK  = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_HOLD   = 2'd3;

  localparam logic [1:0] REG_HOLD   = 2'd0;
  localparam logic [1:0] REG_CLICK  = 2'd1;
  localparam logic [1:0] REG_DOUBLE = 2'd2;
  localparam logic [1:0] REG_ACTIVE = 2'd3;

  localparam logic [15:0] HOLD_RST   = 16'd1000;
  localparam logic [15:0] CLICK_RST  = 16'd250;
  localparam logic [15:0] DOUBLE_RST = 16'd250;
  localparam logic [3:0]  ACTIVE_RST = 4'd0;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [15:0] click_ticks;
    logic [15:0] double_click_ticks;
  } timing_cfg_t;

  typedef struct packed {
    logic [1:0]  evt;
    logic [31:0] stamp;
    logic        level;
  } lane_stat_t;

endpackage

FILE: rtl/bchd_lane.sv
// One switch lane: gesture phase machine, deadline, latched event and level.
// Depends on bchd_pkg.
module bchd_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  scan_en,
  input  logic                  lvl,
  input  logic [31:0]           now_time,
  input  bchd_pkg::timing_cfg_t cfg,
  input  logic                  clr,
  output bchd_pkg::lane_stat_t  stat
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [1:0]  evt_r, evt_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic        level_r, level_nxt;
  logic        d_gt;

  assign d_gt = deadline_r > now_time;

  always_comb begin
    phase_nxt    = phase_r;
    deadline_nxt = deadline_r;
    evt_nxt      = evt_r;
    stamp_nxt    = stamp_r;
    level_nxt    = level_r;
    if (clr) begin
      evt_nxt = bchd_pkg::EV_NONE;
    end
    if (scan_en) begin
      level_nxt = lvl;
      unique case (phase_r)
        bchd_pkg::PH_IDLE: begin
          if (lvl) begin
            phase_nxt    = bchd_pkg::PH_WAIT_UP;
            deadline_nxt = now_time + {16'd0, cfg.hold_ticks};
          end
        end
        bchd_pkg::PH_WAIT_UP: begin
          if (!lvl) begin
            if (d_gt) begin
              phase_nxt    = bchd_pkg::PH_WAIT_P2;
              deadline_nxt = now_time + {16'd0, cfg.click_ticks};
            end else begin
              evt_nxt      = bchd_pkg::EV_HOLD;
              stamp_nxt    = now_time;
              phase_nxt    = bchd_pkg::PH_IDLE;
              deadline_nxt = '0;
            end
          end
        end
        bchd_pkg::PH_WAIT_P2: begin
          if (lvl && d_gt) begin
            phase_nxt    = bchd_pkg::PH_WAIT_U2;
            deadline_nxt = now_time + {16'd0, cfg.double_click_ticks};
          end else if (!d_gt) begin
            evt_nxt      = bchd_pkg::EV_CLICK;
            stamp_nxt    = now_time;
            phase_nxt    = bchd_pkg::PH_IDLE;
            deadline_nxt = '0;
          end
        end
        default: begin
          if (!lvl && d_gt) begin
            evt_nxt      = bchd_pkg::EV_DOUBLE;
            stamp_nxt    = now_time;
            phase_nxt    = bchd_pkg::PH_IDLE;
            deadline_nxt = '0;
          end else if (!d_gt) begin
            phase_nxt    = bchd_pkg::PH_IDLE;
            deadline_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= bchd_pkg::PH_IDLE;
      deadline_r <= '0;
      evt_r      <= bchd_pkg::EV_NONE;
      stamp_r    <= '0;
      level_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      deadline_r <= deadline_nxt;
      evt_r      <= evt_nxt;
      stamp_r    <= stamp_nxt;
      level_r    <= level_nxt;
    end
  end

  assign stat.evt   = evt_r;
  assign stat.stamp = stamp_r;
  assign stat.level = level_r;

endmodule

FILE: rtl/bchd_merge.sv
// Result stage: picks one lane's status on a read and holds it in the output register.
// Depends on bchd_pkg.
module bchd_merge #(
  parameter int NUM_SWITCHES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_take,
  input  logic [2:0]           rd_idx,
  input  bchd_pkg::lane_stat_t stat [NUM_SWITCHES],
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_event_code,
  output logic [31:0]          out_event_stamp,
  output logic                 out_pressed_now
);

  bchd_pkg::lane_stat_t sel;
  bchd_pkg::lane_stat_t res_r;
  logic                 vld_r;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if ({2'b00, rd_idx} == 5'(i)) begin
        sel = stat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rd_take) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_take) begin
      res_r <= sel;
    end
  end

  assign take_ok         = !vld_r || out_ready;
  assign out_valid       = vld_r;
  assign out_event_code  = res_r.evt;
  assign out_event_stamp = res_r.stamp;
  assign out_pressed_now = res_r.level;

endmodule

FILE: rtl/button_click_hold_detector_unit.sv
// Click / double-click / hold detector: one lane per switch plus a result stage.
// A scan item advances every active switch's gesture machine in the cycle it is
// accepted; a read item gives one switch's latched event, stamp and level in the
// next cycle and clears the event. One item is taken a cycle while in_ready is
// high; it is low only while the output register is full and out_ready is low.
// Depends on bchd_pkg, bchd_lane, bchd_merge and assert_macros.svh.
`include "assert_macros.svh"

module button_click_hold_detector_unit #(
  parameter int NUM_SWITCHES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_switch_levels,
  input  logic [31:0] in_now_time,
  input  logic [2:0]  in_switch_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_code,
  output logic [31:0] out_event_stamp,
  output logic        out_pressed_now
);

  bchd_pkg::timing_cfg_t cfg_r;
  logic [3:0]            active_r;
  logic                  cfg_wr;
  logic [1:0]            reg_sel;
  logic                  take;
  logic                  scan_take;
  logic                  rd_take;
  logic                  rd_unknown;
  bchd_pkg::lane_stat_t  stat [NUM_SWITCHES];

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks         <= bchd_pkg::HOLD_RST;
      cfg_r.click_ticks        <= bchd_pkg::CLICK_RST;
      cfg_r.double_click_ticks <= bchd_pkg::DOUBLE_RST;
      active_r                 <= bchd_pkg::ACTIVE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        bchd_pkg::REG_HOLD:   cfg_r.hold_ticks         <= pwdata[15:0];
        bchd_pkg::REG_CLICK:  cfg_r.click_ticks        <= pwdata[15:0];
        bchd_pkg::REG_DOUBLE: cfg_r.double_click_ticks <= pwdata[15:0];
        default:              active_r                 <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bchd_pkg::REG_HOLD:   prdata = {16'd0, cfg_r.hold_ticks};
      bchd_pkg::REG_CLICK:  prdata = {16'd0, cfg_r.click_ticks};
      bchd_pkg::REG_DOUBLE: prdata = {16'd0, cfg_r.double_click_ticks};
      default:              prdata = {28'd0, active_r};
    endcase
  end

  assign take       = in_valid && in_ready;
  assign scan_take  = take && (in_opcode == bchd_pkg::OP_SCAN);
  assign rd_take    = take && (in_opcode == bchd_pkg::OP_READ);
  assign rd_unknown = rd_take && ({3'b000, in_switch_index} >= 6'(NUM_SWITCHES));

  for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
    logic lvl;
    logic act;
    logic clr;

    if (i < 8) begin : g_lvl
      assign lvl = in_switch_levels[i];
    end else begin : g_nolvl
      assign lvl = 1'b0;
    end

    assign act = 5'(i) < {1'b0, active_r};
    assign clr = rd_take && ({2'b00, in_switch_index} == 5'(i));

    bchd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_en  (scan_take && act),
      .lvl      (lvl),
      .now_time (in_now_time),
      .cfg      (cfg_r),
      .clr      (clr),
      .stat     (stat[i])
    );
  end

  bchd_merge #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd_take         (rd_take),
    .rd_idx          (in_switch_index),
    .stat            (stat),
    .take_ok         (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_event_stamp (out_event_stamp),
    .out_pressed_now (out_pressed_now)
  );

  `CHK_NEXT(a_read_gives_result, rd_take, out_valid, "read item gave no result")
  `CHK_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "item taken over a held result")
  `CHK_NEXT(a_unknown_switch_zero, rd_unknown, out_event_code == bchd_pkg::EV_NONE, "unknown switch read gave an event")

endmodule
